>>> rtl/dsts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsts_pkg: shared types and constants
// Field widths, fixed-point constants and the front/back queue item format.
// ----------------------------------------------------------------------------
package dsts_pkg;

	localparam int FREQ_BITS   = 16;
	localparam int DOCLEN_BITS = 24;
	localparam int MU_W        = 20;
	localparam int PROB_W      = 32;
	localparam int BOOST_W     = 24;
	localparam int SCORE_W     = 32;

	localparam logic [MU_W-1:0] MU_RESET = MU_W'(2000);
	localparam logic [31:0]     LN2_Q32  = 32'hB17217F8;

	// doclen + mu
	localparam int DEN_W = ((DOCLEN_BITS > MU_W) ? DOCLEN_BITS : MU_W) + 1;
	localparam int MUP_W = MU_W + PROB_W;
	// mu*p + freq*2^32, one carry bit past 64
	localparam int NUM_W = 65;

	// log2 result: integer part 0..64, 32 fraction bits
	localparam int LOG_FRAC  = 32;
	localparam int LOG_INT_W = 7;
	localparam int LOG_W     = LOG_INT_W + LOG_FRAC;
	// lead detect, normalize, one register per squaring step
	localparam int LOG_LAT   = LOG_FRAC + 2;

	localparam int T_W     = LOG_W + 2;
	localparam int MAG_W   = T_W - 1;
	localparam int LNMAG_W = MAG_W + 1;
	localparam int PROD_W  = LNMAG_W + BOOST_W;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [FREQ_BITS-1:0] freq;
		logic [DEN_W-1:0]     den;
		logic [MU_W-1:0]      mu;
		logic [PROB_W-1:0]    prob;
		logic [BOOST_W-1:0]   boost;
	} dsts_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dsts_qstat_t;

endpackage
`default_nettype wire

>>> rtl/dsts_log2.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsts_log2: pipelined fixed-point log2
// Leading-one search, normalize, then one mantissa squaring per stage.
// ----------------------------------------------------------------------------
module dsts_log2 (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [63:0]               x,
	input  wire logic                      extra,
	output logic [dsts_pkg::LOG_W-1:0]     result
);
	import dsts_pkg::*;

	logic [5:0]  lead;
	logic [5:0]  lead_s1;
	logic [63:0] x_s1;
	logic        ext_s1;
	logic [63:0] norm;

	logic [31:0]          m_s  [0:LOG_FRAC-1];
	logic [LOG_FRAC-1:0]  f_s  [0:LOG_FRAC];
	logic [LOG_INT_W-1:0] ip_s [0:LOG_FRAC];

	always_comb begin
		lead = '0;
		for (int i = 1; i < 64; i++) begin
			if (x[i]) begin
				lead = 6'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lead_s1 <= lead;
			x_s1    <= x;
			ext_s1  <= extra;
		end
	end

	// top one lands on bit 63
	assign norm = x_s1 << (6'd63 - lead_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]  <= norm[63:32];
			f_s[0]  <= '0;
			ip_s[0] <= LOG_INT_W'(lead_s1) + LOG_INT_W'(ext_s1);
		end
	end

	for (genvar g = 0; g < LOG_FRAC; g++) begin : g_sq
		logic [63:0] sq;
		logic [32:0] sh;

		assign sq = {32'd0, m_s[g]} * {32'd0, m_s[g]};
		assign sh = sq[63:31];

		always_ff @(posedge clk) begin
			if (en) begin
				f_s[g+1]  <= {f_s[g][LOG_FRAC-2:0], sh[32]};
				ip_s[g+1] <= ip_s[g];
			end
		end

		if (g < LOG_FRAC - 1) begin : g_m
			always_ff @(posedge clk) begin
				if (en) begin
					m_s[g+1] <= sh[32] ? sh[32:1] : sh[31:0];
				end
			end
		end
	end

	assign result = {ip_s[LOG_FRAC], f_s[LOG_FRAC]};

endmodule
`default_nettype wire

>>> rtl/dsts_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsts_front: input stage
// Takes transfers, patches zero prob/mu, forms doclen+mu, feeds the queue.
// ----------------------------------------------------------------------------
module dsts_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [dsts_pkg::FREQ_BITS-1:0]     term_freq,
	input  wire logic [dsts_pkg::DOCLEN_BITS-1:0]   doc_length,
	input  wire logic [dsts_pkg::PROB_W-1:0]        collection_prob,
	input  wire logic [dsts_pkg::BOOST_W-1:0]       query_boost,
	input  wire logic [dsts_pkg::MU_W-1:0]          mu,
	input  wire dsts_pkg::dsts_qstat_t              qstat,
	output logic                                    push,
	output dsts_pkg::dsts_item_t                    item
);
	import dsts_pkg::*;

	logic       valid_q;
	dsts_item_t item_q;
	logic [MU_W-1:0] mu_fix;

	assign in_stall = valid_q && qstat.full;
	assign push     = valid_q && !qstat.full;
	assign item     = item_q;
	assign mu_fix   = (mu == '0) ? MU_W'(1) : mu;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q.freq  <= term_freq;
			item_q.den   <= DEN_W'(doc_length) + DEN_W'(mu_fix);
			item_q.mu    <= mu_fix;
			item_q.prob  <= (collection_prob == '0) ? PROB_W'(1) : collection_prob;
			item_q.boost <= query_boost;
		end
	end

endmodule
`default_nettype wire

>>> rtl/dsts_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsts_queue: small FIFO between front and back
// ----------------------------------------------------------------------------
module dsts_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire dsts_pkg::dsts_item_t  wr_item,
	input  wire logic                  pop,
	output dsts_pkg::dsts_item_t       rd_item,
	output dsts_pkg::dsts_qstat_t      qstat
);
	import dsts_pkg::*;

	dsts_item_t         mem_q [0:QDEPTH-1];
	logic [QPTR_W-1:0]  wptr_q;
	logic [QPTR_W-1:0]  rptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_push;
	logic               do_pop;

	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign rd_item     = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/dsts_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsts_back: scoring pipeline
// Four log2 units, log sum, ln2 scaling, boost multiply, round and clamp.
// ----------------------------------------------------------------------------
module dsts_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire dsts_pkg::dsts_item_t             rd_item,
	input  wire dsts_pkg::dsts_qstat_t            qstat,
	output logic                                  pop,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [dsts_pkg::SCORE_W-1:0]          term_score,
	output logic                                  was_clamped,
	output logic                                  was_saturated
);
	import dsts_pkg::*;

	logic advance;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, ovalid_q;
	logic vl_s [0:LOG_LAT-1];
	logic [BOOST_W-1:0] bl_s [0:LOG_LAT-1];

	logic [FREQ_BITS-1:0] freq_s1;
	logic [DEN_W-1:0]     den_s1, den_s2;
	logic [MU_W-1:0]      mu_s1, mu_s2;
	logic [MUP_W-1:0]     mup_s1, mup_s2;
	logic [BOOST_W-1:0]   boost_s1, boost_s2, boost_s3, boost_s4, boost_s5, boost_s6;
	logic [NUM_W-1:0]     num_s2;

	logic [LOG_W-1:0] lnum, lmup, lmu, lden;
	logic [63:0]      num_x;

	logic [T_W-1:0]     sum_s3;
	logic [T_W-1:0]     sum_neg;
	logic [MAG_W-1:0]   mag_s4;
	logic               neg_s4, neg_s5, neg_s6, neg_s7;
	logic [63:0]        pl;
	logic [39:0]        ph_s5;
	logic [31:0]        pl_s5;
	logic [LNMAG_W-1:0] lnmag_s6;
	logic [PROD_W-1:0]  prod_s7;
	logic [PROD_W:0]    rnd;
	logic [PROD_W-32:0] rval;

	logic [SCORE_W-1:0] score_q;
	logic               clamp_q;
	logic               sat_q;

	assign advance = !ovalid_q || !out_stall;
	assign pop     = advance && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; ovalid_q <= 1'b0;
			for (int i = 0; i < LOG_LAT; i++) begin
				vl_s[i] <= 1'b0;
			end
		end else if (advance) begin
			v_s1    <= pop;
			v_s2    <= v_s1;
			vl_s[0] <= v_s2;
			for (int i = 1; i < LOG_LAT; i++) begin
				vl_s[i] <= vl_s[i-1];
			end
			v_s3     <= vl_s[LOG_LAT-1];
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			ovalid_q <= v_s7;
		end
	end

	// mu*p, then add freq*2^32
	always_ff @(posedge clk) begin
		if (advance) begin
			mup_s1   <= MUP_W'(rd_item.mu) * MUP_W'(rd_item.prob);
			freq_s1  <= rd_item.freq;
			den_s1   <= rd_item.den;
			mu_s1    <= rd_item.mu;
			boost_s1 <= rd_item.boost;

			num_s2   <= NUM_W'({freq_s1, 32'd0}) + NUM_W'(mup_s1);
			mup_s2   <= mup_s1;
			den_s2   <= den_s1;
			mu_s2    <= mu_s1;
			boost_s2 <= boost_s1;

			bl_s[0] <= boost_s2;
			for (int i = 1; i < LOG_LAT; i++) begin
				bl_s[i] <= bl_s[i-1];
			end
		end
	end

	// carry past bit 63: drop one low bit, exponent + 1
	assign num_x = num_s2[NUM_W-1] ? num_s2[NUM_W-1:1] : num_s2[63:0];

	dsts_log2 u_log_num (.clk(clk), .en(advance), .x(num_x),
		.extra(num_s2[NUM_W-1]), .result(lnum));
	dsts_log2 u_log_mup (.clk(clk), .en(advance), .x(64'(mup_s2)),
		.extra(1'b0), .result(lmup));
	dsts_log2 u_log_mu (.clk(clk), .en(advance), .x(64'(mu_s2)),
		.extra(1'b0), .result(lmu));
	dsts_log2 u_log_den (.clk(clk), .en(advance), .x(64'(den_s2)),
		.extra(1'b0), .result(lden));

	assign sum_neg = ~sum_s3 + 1'b1;
	assign pl      = {32'd0, mag_s4[31:0]} * {32'd0, LN2_Q32};
	assign rnd     = (PROD_W+1)'(prod_s7) + (PROD_W+1)'(64'h8000_0000);
	assign rval    = rnd[PROD_W:32];

	always_ff @(posedge clk) begin
		if (advance) begin
			sum_s3   <= T_W'(lnum) - T_W'(lmup) + T_W'(lmu) - T_W'(lden);
			boost_s3 <= bl_s[LOG_LAT-1];

			neg_s4   <= sum_s3[T_W-1];
			mag_s4   <= sum_s3[T_W-1] ? sum_neg[MAG_W-1:0] : sum_s3[MAG_W-1:0];
			boost_s4 <= boost_s3;

			ph_s5    <= {32'd0, mag_s4[MAG_W-1:32]} * {8'd0, LN2_Q32};
			pl_s5    <= pl[63:32];
			neg_s5   <= neg_s4;
			boost_s5 <= boost_s4;

			lnmag_s6 <= LNMAG_W'(ph_s5) + LNMAG_W'(pl_s5);
			neg_s6   <= neg_s5;
			boost_s6 <= boost_s5;

			prod_s7  <= PROD_W'(lnmag_s6) * PROD_W'(boost_s6);
			neg_s7   <= neg_s6;

			if (neg_s7) begin
				score_q <= '0;
				clamp_q <= (prod_s7 != '0);
				sat_q   <= 1'b0;
			end else if (rval[PROD_W-32:SCORE_W] != '0) begin
				score_q <= '1;
				clamp_q <= 1'b0;
				sat_q   <= 1'b1;
			end else begin
				score_q <= rval[SCORE_W-1:0];
				clamp_q <= 1'b0;
				sat_q   <= 1'b0;
			end
		end
	end

	assign out_valid     = ovalid_q;
	assign term_score    = score_q;
	assign was_clamped   = clamp_q;
	assign was_saturated = sat_q;

endmodule
`default_nettype wire

>>> rtl/dirichlet_smoothed_term_score_core.sv
// Throughput: one item per cycle while the output is not stalled, set by the fully pipelined back end
// (34-stage log2 units, one squaring step per stage).
// A 4-entry queue decouples the front stage from the back pipeline.
// Reset (arst_n low, asynchronous) empties all stages and sets mu to 2000.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dirichlet_smoothed_term_score_core: Dirichlet-smoothed term score
// boost*(ln(1+f/(mu*p)) + ln(mu/(dl+mu))) as Q16.16 with clamp/saturate flags.
// ----------------------------------------------------------------------------
module dirichlet_smoothed_term_score_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration: smoothing_mu
	input  wire logic                               cfg_we,
	input  wire logic [dsts_pkg::MU_W-1:0]          cfg_wdata,
	// input channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [dsts_pkg::FREQ_BITS-1:0]     term_freq,
	input  wire logic [dsts_pkg::DOCLEN_BITS-1:0]   doc_length,
	input  wire logic [dsts_pkg::PROB_W-1:0]        collection_prob,
	input  wire logic [dsts_pkg::BOOST_W-1:0]       query_boost,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [dsts_pkg::SCORE_W-1:0]            term_score,
	output logic                                    was_clamped,
	output logic                                    was_saturated
);
	import dsts_pkg::*;

	logic [MU_W-1:0] mu_q;
	logic            push;
	logic            pop;
	dsts_item_t      wr_item;
	dsts_item_t      rd_item;
	dsts_qstat_t     qstat;

	// mu must only be rewritten while the block is idle (the block itself does not
	// enforce this), so the front stage samples it directly at each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= MU_RESET;
		end else if (cfg_we) begin
			mu_q <= cfg_wdata;
		end
	end

	// Front: one register stage. Holds its item (and stalls the input)
	// only while the queue is full.
	dsts_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.term_freq       (term_freq),
		.doc_length      (doc_length),
		.collection_prob (collection_prob),
		.query_boost     (query_boost),
		.mu              (mu_q),
		.qstat           (qstat),
		.push            (push),
		.item            (wr_item)
	);

	// Queue absorbs output stalls so the front keeps taking transfers until it fills.
	dsts_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.qstat   (qstat)
	);

	// Back: the whole pipeline advances when the output register is free
	// or being taken; bubbles ride along as invalid stages.
	dsts_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_item       (rd_item),
		.qstat         (qstat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.term_score    (term_score),
		.was_clamped   (was_clamped),
		.was_saturated (was_saturated)
	);

`ifndef ASSERT_OFF
	// both flags never set together
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(was_clamped && was_saturated))
		else $error("clamp and saturate both set");

	// a clamped score is zero
	a_clamp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && was_clamped) |-> (term_score == '0))
		else $error("clamped score not zero");

	// queue never reports full and empty together
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue full and empty");

	// input stalls only when the queue is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> qstat.full)
		else $error("input stalled without full queue");
`endif

endmodule
`default_nettype wire
